// ===== rtl/tcspwm_pkg.sv =====
// Package for the three-channel servo PWM block with byte frames.
// Holds beat types, configuration indexes, frame codes and reset values.
// No dependencies; used by tcspwm_core and the top level.
package tcspwm_pkg;

  localparam int PERIOD_W = 10;
  localparam int PULSE_W  = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE    = 2'd2;

  localparam logic [1:0] FRAME_IDLE = 2'd0;
  localparam logic [1:0] FRAME_X    = 2'd1;
  localparam logic [1:0] FRAME_Y    = 2'd2;
  localparam logic [1:0] FRAME_Z    = 2'd3;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_BYTE = 1'b1;

  localparam logic [PULSE_W-1:0]  FRAME_HEADER = 8'hFE;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd400;
  localparam logic [PULSE_W-1:0]  MIN_RESET    = 8'd10;
  localparam logic [PULSE_W-1:0]  MAX_RESET    = 8'd50;
  localparam logic [PULSE_W-1:0]  TARGET_RESET = 8'd30;

  typedef struct packed {
    logic               req_type;
    logic [PULSE_W-1:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic pin_x;
    logic pin_y;
    logic pin_z;
  } out_beat_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

endpackage

// ===== rtl/three_channel_servo_pwm_with_byte_frames_top.sv =====
// Three-channel servo PWM generator fed by tick and byte beats.
// Each accepted result beat is registered in the head entry, or in the skid entry while the head is held.
// Throughput: one beat per cycle; a two-entry output buffer keeps input open while
// a result waits, so input stalls only when both entries are full.
// Reset: synchronous, active low; clears counter, frame and pins, loads default
// targets and configuration. Depends on tcspwm_pkg and tcspwm_core.
module three_channel_servo_pwm_with_byte_frames_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  tcspwm_pkg::in_beat_t                  in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output tcspwm_pkg::out_beat_t                 out_data,
  input  logic                                  cfg_we,
  input  logic [tcspwm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcspwm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  tcspwm_pkg::cfg_wr_t   cfg_wr;
  tcspwm_pkg::out_beat_t result;
  tcspwm_pkg::out_beat_t out_data_r;
  tcspwm_pkg::out_beat_t skid_data_r;
  logic                  out_valid_r;
  logic                  skid_valid_r;
  logic                  accept;
  logic                  pop;

  assign cfg_wr.we    = cfg_we;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.wdata = cfg_wdata;

  assign in_ready  = !skid_valid_r;
  assign accept    = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tcspwm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_wr),
    .accept  (accept),
    .in_beat (in_data),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || pop) begin
        out_data_r  <= result;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= result;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a head entry");

  accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted beat produced no result");

  skid_moves_to_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && pop |=> out_valid_r && !skid_valid_r
    && out_data_r == $past(skid_data_r))
    else $error("skid entry lost on drain");

  skid_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_ready |=> skid_valid_r && $stable(skid_data_r))
    else $error("skid entry changed while stalled");

endmodule

// ===== rtl/tcspwm_core.sv =====
// State of the servo PWM block: configuration, period counter, targets and frame parser.
// Produces the pin levels that result from each accepted beat.
// Depends on tcspwm_pkg.
module tcspwm_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcspwm_pkg::cfg_wr_t  cfg_wr,
  input  logic                 accept,
  input  tcspwm_pkg::in_beat_t in_beat,
  output tcspwm_pkg::out_beat_t result
);

  logic [tcspwm_pkg::PERIOD_W-1:0] period_r;
  logic [tcspwm_pkg::PULSE_W-1:0]  min_r;
  logic [tcspwm_pkg::PULSE_W-1:0]  max_r;
  logic [tcspwm_pkg::PERIOD_W-1:0] count_r, count_nxt;
  logic [tcspwm_pkg::PULSE_W-1:0]  tgt_x_r, tgt_x_nxt;
  logic [tcspwm_pkg::PULSE_W-1:0]  tgt_y_r, tgt_y_nxt;
  logic [tcspwm_pkg::PULSE_W-1:0]  tgt_z_r, tgt_z_nxt;
  logic [1:0]                      frame_r, frame_nxt;
  logic [2:0]                      pins_r, pins_nxt;
  logic [tcspwm_pkg::PERIOD_W:0]   count_inc;
  logic [tcspwm_pkg::PULSE_W-1:0]  raised;
  logic [tcspwm_pkg::PULSE_W-1:0]  clamped;

  always_comb begin
    count_inc = {1'b0, count_r} + {{tcspwm_pkg::PERIOD_W{1'b0}}, 1'b1};
    raised    = (in_beat.rx_byte < min_r) ? min_r : in_beat.rx_byte;
    clamped   = (raised > max_r) ? max_r : raised;
    count_nxt = count_r;
    tgt_x_nxt = tgt_x_r;
    tgt_y_nxt = tgt_y_r;
    tgt_z_nxt = tgt_z_r;
    frame_nxt = frame_r;
    pins_nxt  = pins_r;
    if (in_beat.req_type == tcspwm_pkg::REQ_TICK) begin
      if (count_inc >= {1'b0, period_r}) begin
        count_nxt = '0;
      end else begin
        count_nxt = count_inc[tcspwm_pkg::PERIOD_W-1:0];
      end
      pins_nxt[0] = count_nxt < {2'b00, tgt_x_r};
      pins_nxt[1] = count_nxt < {2'b00, tgt_y_r};
      pins_nxt[2] = count_nxt < {2'b00, tgt_z_r};
    end else if (in_beat.rx_byte == tcspwm_pkg::FRAME_HEADER) begin
      frame_nxt = tcspwm_pkg::FRAME_X;
    end else begin
      case (frame_r)
        tcspwm_pkg::FRAME_X: begin
          tgt_x_nxt = clamped;
          frame_nxt = tcspwm_pkg::FRAME_Y;
        end
        tcspwm_pkg::FRAME_Y: begin
          tgt_y_nxt = clamped;
          frame_nxt = tcspwm_pkg::FRAME_Z;
        end
        tcspwm_pkg::FRAME_Z: begin
          tgt_z_nxt = clamped;
          frame_nxt = tcspwm_pkg::FRAME_IDLE;
        end
        default: begin
          frame_nxt = frame_r;
        end
      endcase
    end
  end

  assign result.pin_x = pins_nxt[0];
  assign result.pin_y = pins_nxt[1];
  assign result.pin_z = pins_nxt[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= tcspwm_pkg::PERIOD_RESET;
      min_r    <= tcspwm_pkg::MIN_RESET;
      max_r    <= tcspwm_pkg::MAX_RESET;
    end else if (cfg_wr.we) begin
      case (cfg_wr.index)
        tcspwm_pkg::CFG_PERIOD_TICKS: period_r <= cfg_wr.wdata;
        tcspwm_pkg::CFG_MIN_PULSE:    min_r <= cfg_wr.wdata[tcspwm_pkg::PULSE_W-1:0];
        tcspwm_pkg::CFG_MAX_PULSE:    max_r <= cfg_wr.wdata[tcspwm_pkg::PULSE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      tgt_x_r <= tcspwm_pkg::TARGET_RESET;
      tgt_y_r <= tcspwm_pkg::TARGET_RESET;
      tgt_z_r <= tcspwm_pkg::TARGET_RESET;
      frame_r <= tcspwm_pkg::FRAME_IDLE;
      pins_r  <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
      tgt_x_r <= tgt_x_nxt;
      tgt_y_r <= tgt_y_nxt;
      tgt_z_r <= tgt_z_nxt;
      frame_r <= frame_nxt;
      pins_r  <= pins_nxt;
    end
  end

  tick_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_beat.req_type == tcspwm_pkg::REQ_TICK
    |=> count_r == '0 || count_r < period_r || !$stable(period_r))
    else $error("tick counter left the period range");

  byte_keeps_pins: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_beat.req_type == tcspwm_pkg::REQ_BYTE |=> $stable(pins_r))
    else $error("byte beat changed the pin levels");

  header_restarts_frame: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_beat.req_type == tcspwm_pkg::REQ_BYTE
    && in_beat.rx_byte == tcspwm_pkg::FRAME_HEADER
    |=> frame_r == tcspwm_pkg::FRAME_X && $stable(tgt_x_r))
    else $error("header byte did not restart the frame");

endmodule
